@@ src/ltkd_pkg.sv @@
// Package for the latest-timestamp key directory.
// Holds the item and result structs, outcome codes and controller/datapath links.
// No dependencies.
`timescale 1ns / 1ps

package ltkd_pkg;

    // Outcome codes carried in each result item
    typedef enum logic [1:0] {
        OUTCOME_INSERTED = 2'd0,
        OUTCOME_REPLACED = 2'd1,
        OUTCOME_KEPT     = 2'd2,
        OUTCOME_FULL     = 2'd3
    } outcome_t;

    localparam int unsigned SLOT_OUT_W = 6;

    // One log record
    typedef struct packed {
        logic [31:0] rec_key;
        logic [31:0] rec_time;
        logic [31:0] rec_size;
        logic [30:0] rec_offset;
        logic [7:0]  file_index;
    } in_item_t;

    // One lookup result
    typedef struct packed {
        outcome_t                outcome;
        logic [SLOT_OUT_W-1:0]   slot_index;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan;
        logic resolve;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic match;
        logic scan_end;
    } dp_status_t;

endpackage

@@ src/ltkd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ltkd_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/ltkd_ctrl.sv @@
// Controller state machine for the key directory: load, scan, resolve.
// Depends on ltkd_pkg.
`timescale 1ns / 1ps

module ltkd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  ltkd_pkg::dp_status_t status,
    output ltkd_pkg::ctrl_cmd_t  cmd,
    output logic               busy,
    output logic               done
);

    import ltkd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESOLVE
    } state_t;

    state_t state_reg;
    logic   done_reg;

    // State and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (status.match || status.scan_end)
                    begin
                        state_reg <= ST_RESOLVE;
                    end
                end
                ST_RESOLVE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Commands follow the state
    always_comb
    begin
        cmd.load    = (state_reg == ST_IDLE) && start;
        cmd.scan    = (state_reg == ST_SCAN);
        cmd.resolve = (state_reg == ST_RESOLVE);
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

@@ src/ltkd_dp.sv @@
// Datapath for the key directory: item register, scan counters, fill count,
// slot memory and result register. Depends on ltkd_pkg and ltkd_ram.
`timescale 1ns / 1ps

module ltkd_dp #(
    parameter int unsigned TABLE_ENTRIES = 64,
    parameter int unsigned FILE_BITS     = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ltkd_pkg::ctrl_cmd_t  cmd,
    input  ltkd_pkg::in_item_t   item,
    output ltkd_pkg::dp_status_t status,
    output ltkd_pkg::result_t    result
);

    import ltkd_pkg::*;

    localparam int unsigned IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int unsigned CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned WORD_W = 32 + 32 + 32 + 31 + FILE_BITS;

    in_item_t          item_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic              pend_reg, pend_next;
    logic              hit_reg, hit_next;
    result_t           result_reg, result_next;

    logic              more;
    logic              key_match;
    logic              issue;
    logic              newer;
    logic              has_room;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;
    logic [31:0]       rd_key;
    logic [31:0]       rd_time;
    logic [FILE_BITS+7:0] file_ext;
    logic [IDX_W+SLOT_OUT_W-1:0] slot_ext;
    logic [IDX_W-1:0]  slot_sel;

    // Slot memory: key, time, size, offset, file number per entry
    ltkd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (scan_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_key  = ram_rdata[WORD_W-1 -: 32];
    assign rd_time = ram_rdata[WORD_W-33 -: 32];

    // Slots fill from zero and are never freed, so valid means below the fill count
    assign more      = (scan_idx_reg < count_reg);
    assign key_match = pend_reg && (rd_key == item_reg.rec_key);
    assign issue     = cmd.scan && more && !key_match;
    assign newer     = (rd_time < item_reg.rec_time);
    assign has_room  = (count_reg < CNT_W'(TABLE_ENTRIES));

    assign status.match    = key_match;
    assign status.scan_end = !more && !pend_reg;

    // Stored word from the held item, file number cut to FILE_BITS
    assign file_ext  = {{FILE_BITS{1'b0}}, item_reg.file_index};
    assign ram_wdata = {item_reg.rec_key, item_reg.rec_time, item_reg.rec_size,
                        item_reg.rec_offset, file_ext[FILE_BITS-1:0]};

    // Reported slot: the matched entry on a hit, else the next free one
    assign slot_sel = hit_reg ? cmp_idx_reg : count_reg[IDX_W-1:0];

    // Reported slot number taken modulo 64
    assign slot_ext = {{SLOT_OUT_W{1'b0}}, slot_sel};

    // Load, scan and resolve
    always_comb
    begin
        count_next    = count_reg;
        scan_idx_next = scan_idx_reg;
        cmp_idx_next  = cmp_idx_reg;
        pend_next     = pend_reg;
        hit_next      = hit_reg;
        result_next   = result_reg;
        ram_we        = 1'b0;
        ram_waddr     = cmp_idx_reg;

        if (cmd.load)
        begin
            scan_idx_next = '0;
            pend_next     = 1'b0;
            hit_next      = 1'b0;
        end

        if (cmd.scan)
        begin
            pend_next = issue;
            if (issue)
            begin
                scan_idx_next = scan_idx_reg + 1'b1;
                cmp_idx_next  = scan_idx_reg[IDX_W-1:0];
            end
            if (key_match)
            begin
                hit_next = 1'b1;
            end
        end

        if (cmd.resolve)
        begin
            if (hit_reg)
            begin
                ram_we             = newer;
                ram_waddr          = cmp_idx_reg;
                result_next.outcome = newer ? OUTCOME_REPLACED : OUTCOME_KEPT;
                result_next.slot_index = slot_ext[SLOT_OUT_W-1:0];
            end
            else if (has_room)
            begin
                ram_we             = 1'b1;
                ram_waddr          = count_reg[IDX_W-1:0];
                count_next         = count_reg + 1'b1;
                result_next.outcome = OUTCOME_INSERTED;
                result_next.slot_index = slot_ext[SLOT_OUT_W-1:0];
            end
            else
            begin
                result_next.outcome    = OUTCOME_FULL;
                result_next.slot_index = '0;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            scan_idx_reg <= '0;
            pend_reg     <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            scan_idx_reg <= scan_idx_next;
            pend_reg     <= pend_next;
            hit_reg      <= hit_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        cmp_idx_reg <= cmp_idx_next;
        result_reg  <= result_next;
    end

    assign result = result_reg;

endmodule

@@ src/latest_timestamp_key_directory.sv @@
// Top level of the latest-timestamp key directory.
// Depends on ltkd_pkg, ltkd_ctrl and ltkd_dp (which holds ltkd_ram).
//
//  channel   ports                 handshake
//  -------   -------------------   -----------------------------------------
//  record    item (in_item_t)      taken when start is high and busy is low
//  result    result (result_t)     shown for one cycle while done is high
//
// With k slots filled the scan reads slots from zero up and stops at a match:
// all k for an absent key, 0 to m for a key in slot m, none for an empty table;
// the slot memory's single read port gives the comparator one key per cycle.
// Reset empties the table at once through the fill count; no clearing pass.
// busy stays high until the result cycle, in which the next item may be taken;
// the receiver cannot stall.
`timescale 1ns / 1ps

module latest_timestamp_key_directory #(
    parameter int unsigned TABLE_ENTRIES = 64,
    parameter int unsigned FILE_BITS     = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ltkd_pkg::in_item_t item,
    output logic               done,
    output ltkd_pkg::result_t  result
);

    import ltkd_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencer
    ltkd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Slot store and compare
    ltkd_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .FILE_BITS     (FILE_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .status (status),
        .result (result)
    );

    // Result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // Result appears only once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // An accepted item makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    // A full table reports slot zero
    a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.outcome == OUTCOME_FULL)) |-> (result.slot_index == '0))
        else $error("table full result with non-zero slot");

endmodule

@@ test/latest_timestamp_key_directory_test.sv @@
// Self-checking testbench for latest_timestamp_key_directory.
// Depends on ltkd_pkg and the RTL under src; keeps its own copy of the slot table
// to predict each outcome and slot, and checks every result item as it appears.
`timescale 1ns / 1ps

module latest_timestamp_key_directory_test;
    import ltkd_pkg::*;

    localparam int unsigned SLOTS       = 64;
    localparam int unsigned FILE_W      = 8;
    localparam int unsigned STALL_LIMIT = 1000;
    localparam int unsigned TAIL_CYCLES = SLOTS + 16;
    localparam int unsigned REPORT_MAX  = 10;
    localparam int unsigned POOL_KEYS   = 48;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    in_item_t item;
    logic     done;
    result_t  result;

    latest_timestamp_key_directory #(
        .TABLE_ENTRIES (SLOTS),
        .FILE_BITS     (FILE_W)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    // Shadow copy of the slot table
    bit              dir_valid  [SLOTS];
    bit [31:0]       dir_key    [SLOTS];
    bit [31:0]       dir_time   [SLOTS];
    bit [31:0]       dir_size   [SLOTS];
    bit [30:0]       dir_offset [SLOTS];
    bit [FILE_W-1:0] dir_file   [SLOTS];

    result_t     expected_outcomes [$];
    bit          idling_on;
    int unsigned records_sent;
    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned stall_cycles;
    int unsigned outcome_tally [4];

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Lowest slot holding this key, or -1
    function automatic int find_slot(input logic [31:0] key);
        int s;
        find_slot = -1;
        for (s = SLOTS - 1; s >= 0; s--)
            if (dir_valid[s] && dir_key[s] == key)
                find_slot = s;
    endfunction

    function automatic bit has_free_slot();
        int s;
        has_free_slot = 1'b0;
        for (s = 0; s < SLOTS; s++)
            if (!dir_valid[s])
                has_free_slot = 1'b1;
    endfunction

    function automatic void store_record(input int s, input in_item_t r);
        dir_valid[s]  = 1'b1;
        dir_key[s]    = r.rec_key;
        dir_time[s]   = r.rec_time;
        dir_size[s]   = r.rec_size;
        dir_offset[s] = r.rec_offset;
        dir_file[s]   = r.file_index[FILE_W-1:0];
    endfunction

    // Look the record up, update the shadow table, return the expected result
    function automatic result_t apply_record(input in_item_t r);
        int      hit;
        int      free_slot;
        int      s;
        result_t res;
        hit       = find_slot(r.rec_key);
        free_slot = -1;
        for (s = SLOTS - 1; s >= 0; s--)
            if (!dir_valid[s])
                free_slot = s;
        res.outcome    = OUTCOME_FULL;
        res.slot_index = '0;
        if (hit >= 0)
        begin
            res.slot_index = SLOT_OUT_W'(hit);
            // strictly newer record wins; equal time keeps the stored entry
            if (dir_time[hit] < r.rec_time)
            begin
                store_record(hit, r);
                res.outcome = OUTCOME_REPLACED;
            end
            else
                res.outcome = OUTCOME_KEPT;
        end
        else if (free_slot >= 0)
        begin
            store_record(free_slot, r);
            res.slot_index = SLOT_OUT_W'(free_slot);
            res.outcome    = OUTCOME_INSERTED;
        end
        return res;
    endfunction

    function automatic in_item_t make_record(input logic [31:0] key, input logic [31:0] stamp,
                                             input logic [31:0] size, input logic [30:0] offset,
                                             input logic [7:0] file_no);
        in_item_t r;
        r.rec_key    = key;
        r.rec_time   = stamp;
        r.rec_size   = size;
        r.rec_offset = offset;
        r.file_index = file_no;
        return r;
    endfunction

    // Timestamp relative to the stored one: newer, equal, older or anything
    function automatic logic [31:0] pick_time(input int slot);
        bit [31:0] old;
        bit [31:0] span;
        int        mode;
        old  = dir_time[slot];
        mode = $urandom_range(0, 9);
        if (mode < 4)
        begin
            if (old == 32'hFFFF_FFFF)
                return old;
            span = 32'hFFFF_FFFF - old;
            if ($urandom_range(0, 1) == 0)
                return old + 32'd1;
            return old + ($urandom % span) + 32'd1;
        end
        else if (mode < 7)
            return old;
        else if (mode < 9)
        begin
            if (old == 32'd0)
                return old;
            return old - (($urandom % old) + 32'd1);
        end
        return $urandom;
    endfunction

    function automatic in_item_t random_record(input logic [31:0] key);
        int          slot;
        logic [31:0] stamp;
        slot  = find_slot(key);
        stamp = (slot >= 0) ? pick_time(slot) : $urandom;
        return make_record(key, stamp, $urandom, 31'($urandom), 8'($urandom_range(0, 255)));
    endfunction

    function automatic logic [31:0] fresh_key();
        logic [31:0] k;
        do
            k = $urandom;
        while (find_slot(k) >= 0);
        return k;
    endfunction

    // Offer one item, with an optional idle burst first, and log its prediction
    task automatic send_record(input in_item_t r);
        int gap;
        gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= r;
        do
            @(posedge clk);
        while (busy);
        expected_outcomes.push_back(apply_record(r));
        records_sent++;
    endtask

    // Hold the sender off until every predicted result has come back
    task automatic wait_for_results();
        start <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // Field extremes, every outcome except full, equal and older timestamps
    task automatic test_directed_cases();
        send_record(make_record(32'h0000_0000, 32'h0000_0000, 32'h0, 31'h0, 8'h00));
        send_record(make_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                31'h7FFF_FFFF, 8'hFF));
        send_record(make_record(32'h0000_0000, 32'h0000_0000, 32'h1234, 31'h10, 8'h01));
        send_record(make_record(32'h0000_0000, 32'h0000_0001, 32'h55, 31'h20, 8'h02));
        send_record(make_record(32'h0000_0000, 32'h0000_0000, 32'h66, 31'h30, 8'h03));
        send_record(make_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 31'h0, 8'h00));
        send_record(make_record(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h1, 31'h1, 8'h80));
        send_record(make_record(32'hA5A5_A5A5, 32'd100, 32'hAAAA_AAAA, 31'h2AAA_AAAA, 8'hAA));
        send_record(make_record(32'hA5A5_A5A5, 32'd101, 32'h5555_5555, 31'h5555_5555, 8'h55));
        send_record(make_record(32'hA5A5_A5A5, 32'd101, 32'h0, 31'h0, 8'h00));
        send_record(make_record(32'hA5A5_A5A5, 32'hFFFF_FFFF, 32'h1, 31'h1, 8'h01));
        // unsigned compare across the top bit
        send_record(make_record(32'h5A5A_5A5A, 32'h8000_0000, 32'h8000_0000,
                                31'h4000_0000, 8'h7F));
        send_record(make_record(32'h5A5A_5A5A, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                31'h3FFF_FFFF, 8'hFE));
        send_record(make_record(32'h0000_0001, 32'd5, 32'd5, 31'd5, 8'd5));
        send_record(make_record(32'h5A5A_5A5A, 32'h8000_0001, 32'd9, 31'd9, 8'd9));
        send_record(make_record(32'h0000_0000, 32'h0000_0002, 32'hFFFF_FFFF,
                                31'h7FFF_FFFF, 8'hFF));
    endtask

    // Repeated visits to a limited set of keys while the table still has room
    task automatic test_revisit_pool();
        logic [31:0] pool [POOL_KEYS];
        int          i;
        for (i = 0; i < POOL_KEYS; i++)
            pool[i] = $urandom;
        for (i = 0; i < 400; i++)
            send_record(random_record(pool[$urandom_range(0, POOL_KEYS - 1)]));
    endtask

    // New keys until no slot is left, then a few that must be refused
    task automatic test_fill_to_capacity();
        int i;
        while (has_free_slot())
            send_record(random_record(fresh_key()));
        for (i = 0; i < 4; i++)
            send_record(random_record(fresh_key()));
    endtask

    // Full table: known keys get replaced or kept, unknown ones are refused
    task automatic test_full_table_traffic();
        int i;
        for (i = 0; i < 930; i++)
        begin
            idling_on = (i < 780);
            if ($urandom_range(0, 9) < 6)
                send_record(random_record(dir_key[$urandom_range(0, SLOTS - 1)]));
            else
                send_record(random_record(fresh_key()));
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result with none expected: outcome %0d slot %0d",
                             $realtime, result.outcome, result.slot_index);
            end
            else
            begin
                want = expected_outcomes.pop_front();
                outcome_tally[want.outcome]++;
                if (result.outcome !== want.outcome || result.slot_index !== want.slot_index)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: mismatch: expected outcome %0d slot %0d, got outcome %0d slot %0d",
                                 $realtime, want.outcome, want.slot_index,
                                 result.outcome, result.slot_index);
                end
            end
        end
    end

    // Watchdog on cycles with no item and no result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles + 1 >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
                $display("latest_timestamp_key_directory_test: errors");
                $finish;
            end
        end
    end

    // Sequence of tests
    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        item         = '0;
        idling_on    = 1'b1;
        records_sent = 0;
        results_seen = 0;
        mismatches   = 0;
        stall_cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        wait_for_results();
        test_revisit_pool();
        wait_for_results();
        test_fill_to_capacity();
        wait_for_results();
        test_full_table_traffic();
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_outcomes.size() != 0)
        begin
            $display("%0d results never arrived", expected_outcomes.size());
            mismatches += expected_outcomes.size();
        end
        $display("%0d records sent, %0d results checked, %0d mismatches",
                 records_sent, results_seen, mismatches);
        $display("outcomes: %0d inserted, %0d replaced, %0d kept, %0d table full",
                 outcome_tally[OUTCOME_INSERTED], outcome_tally[OUTCOME_REPLACED],
                 outcome_tally[OUTCOME_KEPT], outcome_tally[OUTCOME_FULL]);
        if (mismatches == 0)
            $display("latest_timestamp_key_directory_test: clean");
        else
            $display("latest_timestamp_key_directory_test: errors");
        $finish;
    end

endmodule

@@ sim.f @@
src/ltkd_pkg.sv
src/ltkd_ram.sv
src/ltkd_ctrl.sv
src/ltkd_dp.sv
src/latest_timestamp_key_directory.sv
test/latest_timestamp_key_directory_test.sv
